@@ hw/rtl/lvp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lvp_pkg;

  // byte codes that matter
  localparam logic [7:0] SYM_OPEN  = 8'h28;
  localparam logic [7:0] SYM_CLOSE = 8'h29;

  // result field
  localparam int unsigned LONGEST_W = 11;
  localparam logic [LONGEST_W-1:0] LONGEST_MAX = 11'd2047;

  // stream data widths
  localparam int unsigned S_DATA_W = 8;
  localparam int unsigned M_DATA_W = 16;

  // command issued by the front end for each byte
  typedef enum logic [1:0] {
    OP_OTHER,
    OP_OPEN,
    OP_CLOSE,
    OP_BEYOND
  } op_t;

  // control part of a queue entry
  typedef struct packed {
    op_t  op;
    logic last;
  } ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/longest_valid_parens_stack.sv @@
// a string's result is registered once its last byte leaves the command queue
// throughput: one byte per cycle while the queue is not full; the stack keeps its
//   top two entries in registers and prefetches the third from the stack memory,
//   so pushes and pops run back to back; a four-entry queue separates byte
//   classification from stack execution; reset: rst is synchronous, active high;
//   no clearing pass, the stack memory is only ever read below its fill count
`timescale 1ns / 1ps
`default_nettype none

module longest_valid_parens_stack #(
  parameter int unsigned MAX_CHARS = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [lvp_pkg::S_DATA_W-1:0] s_tdata,   // [7:0] symbol
  input  wire logic                         s_tlast,   // last
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [lvp_pkg::M_DATA_W-1:0]      m_tdata    // [10:0] longest, [11] overflow
);

  localparam int unsigned AW = $clog2(MAX_CHARS);
  localparam int unsigned CW = $clog2(MAX_CHARS + 1);
  localparam int unsigned QW = AW + $bits(lvp_pkg::ctl_t);

  logic          f_valid;
  logic          f_ready;
  lvp_pkg::ctl_t f_ctl;
  logic [AW-1:0] f_pos;
  logic          q_valid;
  logic          q_ready;
  lvp_pkg::ctl_t q_ctl;
  logic [AW-1:0] q_pos;
  logic [QW-1:0] q_data;

  // byte classification and position tracking
  lvp_front #(
    .MAX_CHARS(MAX_CHARS),
    .CW(CW),
    .AW(AW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .q_valid(f_valid),
    .q_ready(f_ready),
    .q_ctl(f_ctl),
    .q_pos(f_pos)
  );

  // command queue
  lvp_fifo #(
    .W(QW)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .in_valid(f_valid),
    .in_ready(f_ready),
    .in_data({f_pos, f_ctl}),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_data(q_data)
  );

  assign q_ctl = q_data[$bits(lvp_pkg::ctl_t)-1:0];
  assign q_pos = q_data[QW-1:$bits(lvp_pkg::ctl_t)];

  // stack execution and result
  lvp_back #(
    .MAX_CHARS(MAX_CHARS),
    .CW(CW),
    .AW(AW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_ready(q_ready),
    .q_ctl(q_ctl),
    .q_pos(q_pos),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // a new result only follows a last byte leaving the queue
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(q_valid && q_ready && q_ctl.last))
    else $error("result without a last byte");

  // a last transaction lands in the queue
  a_last_queued: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> q_valid)
    else $error("last byte lost before the queue");

  // an empty queue never holds the input
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> s_tready)
    else $error("input stalled with empty queue");

  // a run never exceeds the string limit
  a_longest_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(m_tdata[lvp_pkg::LONGEST_W-1:0]) <= 32'(MAX_CHARS)))
    else $error("longest run beyond limit");

endmodule

`default_nettype wire

@@ hw/rtl/lvp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lvp_front #(
  parameter int unsigned MAX_CHARS = 1024,
  parameter int unsigned CW = 11,
  parameter int unsigned AW = 10
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [lvp_pkg::S_DATA_W-1:0]   s_tdata,   // [7:0] symbol
  input  wire logic                           s_tlast,   // last
  output logic                                q_valid,
  input  wire logic                           q_ready,
  output lvp_pkg::ctl_t                       q_ctl,
  output logic [AW-1:0]                       q_pos
);

  logic [CW-1:0] position;
  logic [CW-1:0] position_next;
  logic          beyond;
  logic          accept;

  // the queue slot is the only thing that holds the input side
  assign s_tready = q_ready;
  assign q_valid  = s_tvalid;
  assign accept   = s_tvalid && q_ready;
  assign beyond   = (position == CW'(MAX_CHARS));
  assign q_pos    = position[AW-1:0];

  // classify the byte
  always_comb begin
    q_ctl.last = s_tlast;
    if (beyond) begin
      q_ctl.op = lvp_pkg::OP_BEYOND;
    end else begin
      case (s_tdata)
        lvp_pkg::SYM_OPEN:  q_ctl.op = lvp_pkg::OP_OPEN;
        lvp_pkg::SYM_CLOSE: q_ctl.op = lvp_pkg::OP_CLOSE;
        default:            q_ctl.op = lvp_pkg::OP_OTHER;
      endcase
    end
  end

  // byte position, held at the limit, cleared after the last byte
  always_comb begin
    position_next = position;
    if (accept) begin
      if (s_tlast) begin
        position_next = '0;
      end else if (!beyond) begin
        position_next = position + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else begin
      position <= position_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lvp_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lvp_fifo #(
  parameter int unsigned W = 13
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [W-1:0] in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [W-1:0]      out_data
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW = $clog2(DEPTH);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW:0]   cnt;
  logic          push;
  logic          pop;

  assign in_ready  = (cnt != (PW+1)'(DEPTH));
  assign out_valid = (cnt != '0);
  assign out_data  = slots[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + PW'(1);
      if (pop) rp <= rp + PW'(1);
      if (push && !pop) begin
        cnt <= cnt + (PW+1)'(1);
      end else if (pop && !push) begin
        cnt <= cnt - (PW+1)'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wp] <= in_data;
  end

endmodule

`default_nettype wire

@@ hw/rtl/lvp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lvp_back #(
  parameter int unsigned MAX_CHARS = 1024,
  parameter int unsigned CW = 11,
  parameter int unsigned AW = 10
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  output logic                              q_ready,
  input  wire lvp_pkg::ctl_t                q_ctl,
  input  wire logic [AW-1:0]                q_pos,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [lvp_pkg::M_DATA_W-1:0]      m_tdata    // [10:0] longest, [11] overflow
);

  localparam int unsigned EW = (CW > lvp_pkg::LONGEST_W) ? CW : lvp_pkg::LONGEST_W;

  // open-position stack: top two entries cached, third prefetched
  logic [AW-1:0] stack_mem [MAX_CHARS];
  logic [AW-1:0] top, top_next;
  logic [AW-1:0] sec, sec_next;
  logic [AW-1:0] third;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] base, base_next;
  logic [CW-1:0] best, best_next;
  logic          ovf, ovf_next;
  logic [CW-1:0] from_plus_one;
  logic [CW-1:0] run;
  logic          fire;
  logic          push_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] best_ext;
  logic [lvp_pkg::LONGEST_W-1:0] longest_sat;
  logic [lvp_pkg::LONGEST_W-1:0] longest_r;
  logic          ovf_r;

  // only the last byte needs the output register free
  assign q_ready = !q_ctl.last || !m_tvalid || m_tready;
  assign fire    = q_valid && q_ready;
  assign push_en = fire && (q_ctl.op == lvp_pkg::OP_OPEN) && (count < CW'(MAX_CHARS));

  // distance back to the new top, or to the base
  assign from_plus_one = (count > CW'(1)) ? (CW'(sec) + CW'(1)) : base;
  assign run           = CW'(q_pos) + CW'(1) - from_plus_one;

  // execute one command
  always_comb begin
    top_next   = top;
    sec_next   = sec;
    count_next = count;
    base_next  = base;
    best_next  = best;
    ovf_next   = ovf;
    if (fire) begin
      case (q_ctl.op)
        lvp_pkg::OP_OPEN: begin
          if (push_en) begin
            top_next   = q_pos;
            sec_next   = top;
            count_next = count + CW'(1);
          end
        end
        lvp_pkg::OP_CLOSE: begin
          if (count != '0) begin
            top_next   = sec;
            sec_next   = third;
            count_next = count - CW'(1);
            if (run > best) best_next = run;
          end else begin
            base_next = CW'(q_pos) + CW'(1);
          end
        end
        lvp_pkg::OP_BEYOND: ovf_next = 1'b1;
        default: ;
      endcase
    end
  end

  // clamp to the result field
  assign best_ext    = EW'(best_next);
  assign longest_sat = (best_ext > EW'(lvp_pkg::LONGEST_MAX)) ?
                       lvp_pkg::LONGEST_MAX : best_ext[lvp_pkg::LONGEST_W-1:0];

  // state registers, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      base  <= '0;
      best  <= '0;
      ovf   <= 1'b0;
    end else if (fire && q_ctl.last) begin
      count <= '0;
      base  <= '0;
      best  <= '0;
      ovf   <= 1'b0;
    end else begin
      count <= count_next;
      base  <= base_next;
      best  <= best_next;
      ovf   <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
    sec <= sec_next;
  end

  // prefetch the entry below the cached pair
  assign rd_en   = !(fire && q_ctl.last) && (count_next >= CW'(3));
  assign rd_addr = AW'(count_next - CW'(3));

  always_ff @(posedge clk) begin
    if (push_en) stack_mem[count[AW-1:0]] <= q_pos;
    if (rd_en) third <= stack_mem[rd_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && q_ctl.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && q_ctl.last) begin
      longest_r <= longest_sat;
      ovf_r     <= ovf_next;
    end
  end

  assign m_tdata = {{(lvp_pkg::M_DATA_W - lvp_pkg::LONGEST_W - 1){1'b0}}, ovf_r, longest_r};

endmodule

`default_nettype wire
